// File: rtl/core/varint_length_frame_decoder_defines.svh
// assertion helpers for the varint frame decoder
`ifndef VARINT_LENGTH_FRAME_DECODER_DEFINES_SVH
`define VARINT_LENGTH_FRAME_DECODER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define VLFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define VLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/vlfd_pkg.sv
`timescale 1ns / 1ps

package vlfd_pkg;

	localparam int VARINT_MAX_BYTES = 5;

	localparam int BYTE_W     = 8;
	localparam int PID_W      = 32;
	localparam int DECL_W     = 21;
	localparam int CODE_W     = 2;
	localparam int KIND_W     = 3;
	localparam int THR_W      = 22;
	localparam int REM_W      = 22;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 22;
	localparam int M_TDATA_W  = 64;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

	localparam logic [THR_W-1:0]  THR_RESET = '1;
	localparam logic [DECL_W-1:0] MAX_RESET = '1;

	typedef enum logic [2:0] {
		PH_OUTER,
		PH_INNER,
		PH_PID,
		PH_BODY,
		PH_RAW,
		PH_SKIP
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PACKET_ID,
		KIND_BODY,
		KIND_HEADER,
		KIND_COMPRESSED,
		KIND_ERROR
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		ERR_MALFORMED,
		ERR_TOO_LARGE,
		ERR_BELOW_THRESHOLD
	} err_t;

endpackage

// File: rtl/core/varint_length_frame_decoder.sv
`timescale 1ns / 1ps
// Deframer for varint length-prefixed streams. One stream byte enters per item on the
// s_axis side and at most one result item leaves on the m_axis side; a new byte is taken
// every clock cycle as long as the result side keeps up. A byte passes an input register
// and then one stage of decode logic into the result register. An outer length that is
// overlong, negative or above max_length stops the block for good: further bytes are
// taken and dropped until reset. Errors inside a frame only drop the rest of that
// frame. Configuration writes on the cfg port are always taken and must come while no
// frame is in flight; the inner length field is used when compression_threshold is
// non-negative at the moment the outer length completes.

`include "varint_length_frame_decoder_defines.svh"

module varint_length_frame_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [vlfd_pkg::BYTE_W-1:0]         s_axis_tdata,   // data_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_byte, msg_id, declared_length, error_code, zero pad
	output logic [vlfd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	output logic [vlfd_pkg::KIND_W-1:0]         m_axis_tuser,   // kind
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vlfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vlfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import vlfd_pkg::*;

	// configuration
	logic [THR_W-1:0]  thr_q;
	logic [DECL_W-1:0] max_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// decoder state
	phase_t            phase_q, phase_d;
	logic [PID_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic              stuck_q, stuck_d;

	// result register
	logic              out_valid_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] obyte_q;
	logic [PID_W-1:0]  pid_q;
	logic [DECL_W-1:0] decl_q;
	err_t              code_q;
	logic              last_q;

	// combinational result
	logic              res_valid;
	kind_t             res_kind;
	logic [BYTE_W-1:0] res_byte;
	logic [PID_W-1:0]  res_pid;
	logic [DECL_W-1:0] res_decl;
	err_t              res_code;
	logic              res_last;

	logic advance, fire;

	// varint step
	logic [PID_W-1:0] acc_base, acc_shift, acc_new;
	logic [CNT_W-1:0] cnt_inc, cnt_nx;
	logic             vi_done, vi_long;
	logic [REM_W-1:0] rem_dec;
	logic             rem_dec_zero;
	logic             above_max, below_thr;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			max_q <= MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD:  thr_q <= cfg_data[THR_W-1:0];
				REG_MAX_LENGTH: max_q <= cfg_data[DECL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		acc_base = (cnt_q == '0) ? '0 : acc_q;
		case (cnt_q)
			3'd0:    acc_shift = {25'd0, byte_s1[6:0]};
			3'd1:    acc_shift = {18'd0, byte_s1[6:0], 7'd0};
			3'd2:    acc_shift = {11'd0, byte_s1[6:0], 14'd0};
			3'd3:    acc_shift = {4'd0, byte_s1[6:0], 21'd0};
			3'd4:    acc_shift = {byte_s1[3:0], 28'd0};
			default: acc_shift = '0;
		endcase
		acc_new  = acc_base | acc_shift;
		cnt_inc  = cnt_q + CNT_W'(1);
		vi_done  = !byte_s1[7];
		vi_long  = byte_s1[7] && (cnt_inc >= CNT_W'(VARINT_MAX_BYTES));
		cnt_nx   = (vi_done || vi_long) ? '0 : cnt_inc;
		rem_dec  = (rem_q != '0) ? rem_q - REM_W'(1) : '0;
		rem_dec_zero = (rem_dec == '0);
		above_max    = acc_new > {11'd0, max_q};
		below_thr    = $signed({1'b0, acc_new[DECL_W-1:0]}) < $signed(thr_q);
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		rem_d   = rem_q;
		stuck_d = stuck_q;
		if (fire && !stuck_q) begin
			case (phase_q)
				PH_OUTER: begin
					acc_d = acc_new;
					cnt_d = cnt_nx;
					if (vi_long) begin
						stuck_d = 1'b1;
					end else if (vi_done) begin
						if (acc_new[PID_W-1] || above_max) begin
							stuck_d = 1'b1;
						end else begin
							rem_d = acc_new[REM_W-1:0];
							if (acc_new != '0) begin
								phase_d = thr_q[THR_W-1] ? PH_PID : PH_INNER;
							end
						end
					end
				end
				PH_INNER, PH_PID: begin
					acc_d = acc_new;
					cnt_d = cnt_nx;
					rem_d = rem_dec;
					if (vi_long || (!vi_done && rem_dec_zero)) begin
						cnt_d   = '0;
						phase_d = rem_dec_zero ? PH_OUTER : PH_SKIP;
					end else if (vi_done) begin
						if (phase_q == PH_PID) begin
							phase_d = rem_dec_zero ? PH_OUTER : PH_BODY;
						end else if (acc_new[PID_W-1] || above_max
							|| ((acc_new == '0) && rem_dec_zero)
							|| ((acc_new != '0) && below_thr)) begin
							phase_d = rem_dec_zero ? PH_OUTER : PH_SKIP;
						end else if (acc_new == '0) begin
							phase_d = PH_PID;
						end else begin
							phase_d = rem_dec_zero ? PH_OUTER : PH_RAW;
						end
					end
				end
				PH_BODY, PH_RAW, PH_SKIP: begin
					rem_d = rem_dec;
					if (rem_dec_zero) begin
						phase_d = PH_OUTER;
					end
				end
				default: begin
					phase_d = PH_OUTER;
				end
			endcase
		end
	end

	// result item
	always_comb begin
		res_valid = 1'b0;
		res_kind  = KIND_ERROR;
		res_byte  = '0;
		res_pid   = '0;
		res_decl  = '0;
		res_code  = ERR_MALFORMED;
		res_last  = 1'b1;
		if (!stuck_q) begin
			case (phase_q)
				PH_OUTER: begin
					if (vi_long) begin
						res_valid = 1'b1;
					end else if (vi_done) begin
						if (acc_new[PID_W-1] || acc_new == '0) begin
							res_valid = 1'b1;
						end else if (above_max) begin
							res_valid = 1'b1;
							res_code  = ERR_TOO_LARGE;
						end
					end
				end
				PH_INNER: begin
					if (vi_long || (!vi_done && rem_dec_zero)) begin
						res_valid = 1'b1;
					end else if (vi_done) begin
						if (acc_new[PID_W-1] || ((acc_new == '0) && rem_dec_zero)) begin
							res_valid = 1'b1;
						end else if (acc_new == '0) begin
							res_valid = 1'b0;
						end else if (above_max) begin
							res_valid = 1'b1;
							res_code  = ERR_TOO_LARGE;
						end else if (below_thr) begin
							res_valid = 1'b1;
							res_code  = ERR_BELOW_THRESHOLD;
						end else begin
							res_valid = 1'b1;
							res_kind  = KIND_HEADER;
							res_decl  = acc_new[DECL_W-1:0];
							res_last  = rem_dec_zero;
						end
					end
				end
				PH_PID: begin
					if (vi_long || (!vi_done && rem_dec_zero)) begin
						res_valid = 1'b1;
					end else if (vi_done) begin
						res_valid = 1'b1;
						res_kind  = KIND_PACKET_ID;
						res_pid   = acc_new;
						res_last  = rem_dec_zero;
					end
				end
				PH_BODY, PH_RAW: begin
					res_valid = 1'b1;
					res_kind  = (phase_q == PH_BODY) ? KIND_BODY : KIND_COMPRESSED;
					res_byte  = byte_s1;
					res_last  = rem_dec_zero;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OUTER;
			acc_q       <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			stuck_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			stuck_q <= stuck_d;
			if (advance) begin
				out_valid_q <= fire && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q  <= res_kind;
			obyte_q <= res_byte;
			pid_q   <= res_pid;
			decl_q  <= res_decl;
			code_q  <= res_code;
			last_q  <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {1'b0, code_q, decl_q, pid_q, obyte_q};

	`VLFD_ASSERT_SAME(a_err_last, clk, arst_n, m_axis_tvalid && (kind_q == KIND_ERROR), m_axis_tlast, "error item without tlast")
	`VLFD_ASSERT_SAME(a_outer_empty, clk, arst_n, phase_q == PH_OUTER, rem_q == '0, "frame count left while waiting for a length")
	`VLFD_ASSERT_NEXT(a_stuck_hold, clk, arst_n, stuck_q, stuck_q, "sticky error cleared")
	`VLFD_ASSERT_NEXT(a_stuck_silent, clk, arst_n, stuck_q && !m_axis_tvalid, !m_axis_tvalid, "item produced after sticky error")
	`VLFD_ASSERT_SAME(a_code_zero, clk, arst_n, m_axis_tvalid && (kind_q != KIND_ERROR), code_q == ERR_MALFORMED, "error code on a data item")

endmodule

// File: tb/varint_length_frame_decoder_checker.sv
`timescale 1ns / 1ps

module varint_length_frame_decoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [vlfd_pkg::BYTE_W-1:0]     s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [vlfd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic [vlfd_pkg::KIND_W-1:0]     m_axis_tuser,
	input  logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [vlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vlfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              pending
);

	import vlfd_pkg::*;

	localparam int OFS_PID  = BYTE_W;
	localparam int OFS_DECL = OFS_PID + PID_W;
	localparam int OFS_CODE = OFS_DECL + DECL_W;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] out_byte;
		logic [PID_W-1:0]  pid;
		logic [DECL_W-1:0] decl;
		err_t              code;
		logic              last;
	} frame_out_t;

	typedef enum {VARINT_MORE, VARINT_DONE, VARINT_OVERLONG} varint_st_t;

	logic [THR_W-1:0]  threshold;
	logic [DECL_W-1:0] max_len;
	phase_t            phase;
	logic [31:0]       acc;
	logic [CNT_W-1:0]  nbytes;
	logic [REM_W-1:0]  remaining;
	bit                locked;
	frame_out_t        expected_q[$];

	function automatic frame_out_t result_of(kind_t k, logic [BYTE_W-1:0] b,
		logic [PID_W-1:0] p, logic [DECL_W-1:0] d, err_t c, logic l);
		frame_out_t r;
		r.kind = k;
		r.out_byte = b;
		r.pid = p;
		r.decl = d;
		r.code = c;
		r.last = l;
		return r;
	endfunction

	function automatic varint_st_t take_varint(logic [7:0] b);
		int n;
		n = (nbytes >= VARINT_MAX_BYTES) ? 0 : int'(nbytes);
		if (n == 0)
			acc = '0;
		acc = acc | (32'(b[6:0]) << (7 * n));
		n++;
		if (!b[7]) begin
			nbytes = '0;
			return VARINT_DONE;
		end
		if (n >= VARINT_MAX_BYTES) begin
			nbytes = '0;
			return VARINT_OVERLONG;
		end
		nbytes = CNT_W'(n);
		return VARINT_MORE;
	endfunction

	// error inside a frame: drop what is left of it
	function automatic frame_out_t frame_fault(err_t c);
		nbytes = '0;
		phase = (remaining != 0) ? PH_SKIP : PH_OUTER;
		return result_of(KIND_ERROR, '0, '0, '0, c, 1'b1);
	endfunction

	// bad outer length: stream is dead until reset
	function automatic frame_out_t stream_fault(err_t c);
		locked = 1'b1;
		nbytes = '0;
		return result_of(KIND_ERROR, '0, '0, '0, c, 1'b1);
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output frame_out_t r);
		varint_st_t         st;
		logic [31:0]        v;
		logic signed [31:0] thr_ext;
		kind_t              k;
		r = '0;
		thr_ext = {{(32 - THR_W){threshold[THR_W-1]}}, threshold};
		if (locked)
			return 1'b0;
		if (phase == PH_OUTER) begin
			st = take_varint(b);
			if (st == VARINT_MORE)
				return 1'b0;
			if (st == VARINT_OVERLONG || acc[31]) begin
				r = stream_fault(ERR_MALFORMED);
				return 1'b1;
			end
			if (acc > 32'(max_len)) begin
				r = stream_fault(ERR_TOO_LARGE);
				return 1'b1;
			end
			remaining = acc[REM_W-1:0];
			if (remaining == 0) begin
				r = frame_fault(ERR_MALFORMED);
				return 1'b1;
			end
			phase = threshold[THR_W-1] ? PH_PID : PH_INNER;
			return 1'b0;
		end
		if (remaining != 0)
			remaining = remaining - REM_W'(1);
		case (phase)
			PH_INNER: begin
				st = take_varint(b);
				if (st == VARINT_OVERLONG) begin
					r = frame_fault(ERR_MALFORMED);
					return 1'b1;
				end
				if (st == VARINT_MORE) begin
					if (remaining != 0)
						return 1'b0;
					r = frame_fault(ERR_MALFORMED);
					return 1'b1;
				end
				v = acc;
				if (v[31]) begin
					r = frame_fault(ERR_MALFORMED);
					return 1'b1;
				end
				if (v == 0) begin
					if (remaining == 0) begin
						r = frame_fault(ERR_MALFORMED);
						return 1'b1;
					end
					phase = PH_PID;
					return 1'b0;
				end
				if (v > 32'(max_len)) begin
					r = frame_fault(ERR_TOO_LARGE);
					return 1'b1;
				end
				if ($signed(v) < thr_ext) begin
					r = frame_fault(ERR_BELOW_THRESHOLD);
					return 1'b1;
				end
				r = result_of(KIND_HEADER, '0, '0, v[DECL_W-1:0], ERR_MALFORMED, remaining == 0);
				phase = (remaining != 0) ? PH_RAW : PH_OUTER;
				return 1'b1;
			end
			PH_PID: begin
				st = take_varint(b);
				if (st == VARINT_OVERLONG) begin
					r = frame_fault(ERR_MALFORMED);
					return 1'b1;
				end
				if (st == VARINT_MORE) begin
					if (remaining != 0)
						return 1'b0;
					r = frame_fault(ERR_MALFORMED);
					return 1'b1;
				end
				r = result_of(KIND_PACKET_ID, '0, acc, '0, ERR_MALFORMED, remaining == 0);
				phase = (remaining != 0) ? PH_BODY : PH_OUTER;
				return 1'b1;
			end
			PH_BODY, PH_RAW: begin
				k = (phase == PH_BODY) ? KIND_BODY : KIND_COMPRESSED;
				r = result_of(k, b, '0, '0, ERR_MALFORMED, remaining == 0);
				if (remaining == 0)
					phase = PH_OUTER;
				return 1'b1;
			end
			default: begin
				if (remaining == 0)
					phase = PH_OUTER;
				return 1'b0;
			end
		endcase
	endfunction

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: result %s mismatch, got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		frame_out_t r;
		frame_out_t want;
		if (!arst_n) begin
			threshold = THR_RESET;
			max_len = MAX_RESET;
			phase = PH_OUTER;
			acc = '0;
			nbytes = '0;
			remaining = '0;
			locked = 1'b0;
			expected_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD:  threshold = cfg_data[THR_W-1:0];
					REG_MAX_LENGTH: max_len = cfg_data[DECL_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected item, kind", 32'(m_axis_tuser), '0);
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tuser !== want.kind)
						report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
					if (m_axis_tdata[BYTE_W-1:0] !== want.out_byte)
						report_mismatch("out_byte", 32'(m_axis_tdata[BYTE_W-1:0]),
							32'(want.out_byte));
					if (m_axis_tdata[OFS_PID +: PID_W] !== want.pid)
						report_mismatch("msg_id", m_axis_tdata[OFS_PID +: PID_W], want.pid);
					if (m_axis_tdata[OFS_DECL +: DECL_W] !== want.decl)
						report_mismatch("declared_length", 32'(m_axis_tdata[OFS_DECL +: DECL_W]),
							32'(want.decl));
					if (m_axis_tdata[OFS_CODE +: CODE_W] !== want.code)
						report_mismatch("error_code", 32'(m_axis_tdata[OFS_CODE +: CODE_W]),
							32'(want.code));
					if (m_axis_tlast !== want.last)
						report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (decode_byte(s_axis_tdata, r))
					expected_q.push_back(r);
			end
			pending <= expected_q.size();
		end
	end

endmodule

// File: tb/varint_length_frame_decoder_tb.sv
`timescale 1ns / 1ps

module varint_length_frame_decoder_tb;
	import vlfd_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 8;
	localparam int PHASE_BYTES   = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [KIND_W-1:0]     m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int                mismatches;
	int                pending;
	int                quiet = 0;
	int                sent = 0;
	bit                tx_idle = 1'b1;
	bit                rx_idle = 1'b1;
	bit                hold_req = 1'b0;
	logic [THR_W-1:0]  cur_thr = THR_RESET;
	logic [DECL_W-1:0] cur_max = MAX_RESET;
	byte unsigned      payload_q[$];

	always begin
		#5;
		clk = 1'b1;
		#5;
		clk = 1'b0;
	end

	varint_length_frame_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	varint_length_frame_decoder_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin : sink
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= !rx_idle || ($urandom_range(99) >= 25);
		end
	end

	task send_byte(input logic [7:0] b);
		while (tx_idle && $urandom_range(99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	function automatic int min_varint_len(logic [31:0] v);
		int n;
		n = 1;
		while (n < VARINT_MAX_BYTES && (v >> (7 * n)) != 0)
			n++;
		return n;
	endfunction

	// mostly minimal encodings, sometimes padded with zero groups
	function automatic int pick_varint_len(logic [31:0] v);
		int n;
		n = min_varint_len(v);
		if ($urandom_range(4) == 0)
			n = $urandom_range(VARINT_MAX_BYTES, n);
		return n;
	endfunction

	function automatic void add_varint(logic [31:0] v, int n, bit endless);
		for (int i = 0; i < n; i++)
			payload_q.push_back({(i < n - 1) || endless, 7'(v >> (7 * i))});
	endfunction

	task send_frame();
		int len;
		int n;
		len = payload_q.size();
		n = pick_varint_len(len);
		for (int i = 0; i < n; i++)
			send_byte({i < n - 1, 7'(len >> (7 * i))});
		foreach (payload_q[i])
			send_byte(payload_q[i]);
		payload_q.delete();
	endtask

	task add_body(input int n);
		repeat (n) payload_q.push_back(8'($urandom));
	endtask

	function automatic int body_len();
		return ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
	endfunction

	task add_packet_id();
		logic [31:0] id;
		int          n;
		case ($urandom_range(3))
			0: id = $urandom_range(127);
			1: id = $urandom_range(16383);
			2: id = $urandom;
			default: id = 32'h8000_0000 | $urandom;
		endcase
		n = pick_varint_len(id);
		add_varint(id, n, 1'b0);
		// bits above 32 in a fifth byte are dropped
		if (n == VARINT_MAX_BYTES)
			payload_q[payload_q.size() - 1] |= 8'($urandom_range(7)) << 4;
	endtask

	task random_frame();
		bit          compressed;
		int          lo;
		int          thr;
		logic [31:0] v;
		compressed = !cur_thr[THR_W-1];
		thr = int'(cur_thr);
		lo = (thr > 1) ? thr : 1;
		if ($urandom_range(99) < 80) begin
			if (compressed && $urandom_range(1)) begin
				if ($urandom_range(1))
					v = lo + $urandom_range(15);
				else
					v = $urandom_range(int'(cur_max), lo);
				if (v > cur_max)
					v = cur_max;
				add_varint(v, pick_varint_len(v), 1'b0);
			end else begin
				if (compressed)
					add_varint(0, pick_varint_len(0), 1'b0);
				add_packet_id();
			end
			add_body(body_len());
		end else begin
			case ($urandom_range(5))
				0: add_body($urandom_range(8));
				1: begin
					repeat (VARINT_MAX_BYTES) payload_q.push_back(8'h80 | 8'($urandom));
					add_body($urandom_range(4));
				end
				2: repeat ($urandom_range(4, 1)) payload_q.push_back(8'h80 | 8'($urandom));
				3: begin
					add_varint(32'h8000_0000 | $urandom, VARINT_MAX_BYTES, 1'b0);
					add_body($urandom_range(4));
				end
				4: begin
					if (compressed && thr > 1 && $urandom_range(1))
						v = $urandom_range(thr - 1, 1);
					else
						v = cur_max + 1 + $urandom_range(1000);
					add_varint(v, pick_varint_len(v), 1'b0);
					add_body($urandom_range(4));
				end
				default: payload_q.push_back(8'h00);
			endcase
		end
		while (payload_q.size() > cur_max)
			void'(payload_q.pop_back());
		send_frame();
	endtask

	task random_phase(input int nbytes);
		int stop;
		stop = sent + nbytes;
		while (sent < stop)
			random_frame();
	endtask

	task wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task set_config(input logic [THR_W-1:0] thr_val, input logic [DECL_W-1:0] max_val);
		cfg_valid <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr_val);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MAX_LENGTH;
		cfg_data <= CFG_DATA_W'(max_val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_thr = thr_val;
		cur_max = max_val;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain mode: empty frame, zero id, widest id with dropped bits, overlong id
		send_frame();
		payload_q = '{8'h00};
		send_frame();
		payload_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80};
		send_frame();
		payload_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h55};
		send_frame();
		random_phase(PHASE_BYTES);
		wait_idle();

		// compressed mode with the lowest threshold
		set_config('0, MAX_RESET);
		payload_q = '{8'h00, 8'h05, 8'hAA};
		send_frame();
		payload_q = '{8'hFF, 8'hFF, 8'h7F};
		send_frame();
		payload_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
		send_frame();
		random_phase(PHASE_BYTES);
		wait_idle();

		set_config(THR_W'($urandom_range(4096, 2)), DECL_W'($urandom_range(100000, 4096)));
		random_phase(PHASE_BYTES);
		wait_idle();

		set_config(THR_W'(22'h1F_FFFF), MAX_RESET);
		random_phase(120);
		wait_idle();

		// most negative threshold, tiny frame limit
		set_config(THR_W'(22'h20_0000), DECL_W'($urandom_range(20, 4)));
		random_phase(150);
		wait_idle();

		// back-pressure with no idling anywhere
		set_config(THR_RESET, MAX_RESET);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = 1'b1;
		random_phase(250);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		wait_idle();

		// finally kill the stream with a bad outer length
		set_config(THR_RESET, '0);
		send_frame();
		send_frame();
		case ($urandom_range(2))
			0: send_byte(8'h01);
			1: begin
				repeat (4) send_byte(8'hFF);
				send_byte(8'h0F);
			end
			default: repeat (VARINT_MAX_BYTES) send_byte(8'h80 | 8'($urandom));
		endcase
		repeat (20) send_byte(8'($urandom));
		wait_idle();

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
